// File: rtl/core/mf3_pkg.sv
// Shared types, constants and compare helpers for the 3x3 median filter.
`default_nettype none

package mf3_pkg;

    localparam int PIXEL_BITS       = 8;
    localparam int PLANE_W          = 2;
    localparam int COORD_W          = 11;
    localparam int CFG_W            = 12;
    localparam int CFG_IDX_W        = 1;
    localparam int MAX_WIDTH_DEF    = 2048;
    localparam int MAX_HEIGHT       = 2048;
    localparam int FRAME_WIDTH_RST  = 640;
    localparam int FRAME_HEIGHT_RST = 480;
    localparam int IN_DATA_W        = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W       = ((PIXEL_BITS + 2 * COORD_W + 7) / 8) * 8;

    typedef logic [PIXEL_BITS-1:0] pix_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // Which results an item produces, decided when the item is accepted.
    typedef struct packed {
        logic res_center;   // pixel one up and one left of the input
        logic use_median;   // that pixel is interior
        logic res_edge;     // right edge pixel of the row above
        logic res_self;     // last row: the input copied through
        logic done;         // last pixel of the plane
    } item_ctl_t;

    typedef struct packed {
        pix_t lo;
        pix_t md;
        pix_t hi;
    } trio_t;

    function automatic pix_t min2(input pix_t a, input pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pix_t max2(input pix_t a, input pix_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
        return min2(min2(a, b), c);
    endfunction

    function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
        return max2(max2(a, b), c);
    endfunction

    function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    function automatic trio_t sort3(input pix_t a, input pix_t b, input pix_t c);
        trio_t t;
        pix_t  lo1;
        pix_t  hi1;
        pix_t  mid;
        lo1  = min2(a, b);
        hi1  = max2(a, b);
        mid  = min2(hi1, c);
        t.hi = max2(hi1, c);
        t.lo = min2(lo1, mid);
        t.md = max2(lo1, mid);
        return t;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/mf3_line_buf.sv
// Dual line buffer memory: one entry per column holds the two rows above.
`default_nettype none

module mf3_line_buf #(
    parameter int DEPTH = mf3_pkg::MAX_WIDTH_DEF,
    parameter int DW    = 2 * mf3_pkg::PIXEL_BITS
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DW-1:0]            rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DW-1:0]            wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/core/mf3_window.sv
// 3x3 window of column-sorted pixels and the first median reduction level.
`default_nettype none

module mf3_window #(
    parameter int AW = 11
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  mf3_pkg::pix_t              new_top,
    input  mf3_pkg::pix_t              new_mid,
    input  mf3_pkg::pix_t              new_bot,
    input  logic [mf3_pkg::PLANE_W-1:0] in_plane,
    input  logic [AW-1:0]              in_col,
    input  logic [mf3_pkg::COORD_W-1:0] in_row,
    input  mf3_pkg::item_ctl_t         in_ctl,
    output mf3_pkg::pix_t              win_pix,
    output logic [mf3_pkg::PLANE_W-1:0] win_plane,
    output logic [AW-1:0]              win_col,
    output logic [mf3_pkg::COORD_W-1:0] win_row,
    output mf3_pkg::item_ctl_t         win_ctl,
    output mf3_pkg::pix_t              mid_prev,
    output mf3_pkg::pix_t              mid_cur,
    output mf3_pkg::pix_t              max_lo,
    output mf3_pkg::pix_t              med_md,
    output mf3_pkg::pix_t              min_hi
);

    import mf3_pkg::*;

    // Column 2 is the newest; each column is stored already sorted.
    trio_t                col_reg [3];
    pix_t                 mid_prev_reg;
    pix_t                 mid_cur_reg;
    pix_t                 pix_reg;
    logic [PLANE_W-1:0]   plane_reg;
    logic [AW-1:0]        colidx_reg;
    logic [COORD_W-1:0]   row_reg;
    item_ctl_t            ctl_reg;
    trio_t                col_next;

    always_comb
    begin
        col_next = sort3(new_top, new_mid, new_bot);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg[0]   <= '0;
            col_reg[1]   <= '0;
            col_reg[2]   <= '0;
            mid_prev_reg <= '0;
            mid_cur_reg  <= '0;
        end
        else if (load)
        begin
            col_reg[0]   <= col_reg[1];
            col_reg[1]   <= col_reg[2];
            col_reg[2]   <= col_next;
            mid_prev_reg <= mid_cur_reg;
            mid_cur_reg  <= new_mid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pix_reg    <= new_bot;
            plane_reg  <= in_plane;
            colidx_reg <= in_col;
            row_reg    <= in_row;
            ctl_reg    <= in_ctl;
        end
    end

    assign win_pix   = pix_reg;
    assign win_plane = plane_reg;
    assign win_col   = colidx_reg;
    assign win_row   = row_reg;
    assign win_ctl   = ctl_reg;
    assign mid_prev  = mid_prev_reg;
    assign mid_cur   = mid_cur_reg;
    assign max_lo    = max3(col_reg[0].lo, col_reg[1].lo, col_reg[2].lo);
    assign med_md    = med3(col_reg[0].md, col_reg[1].md, col_reg[2].md);
    assign min_hi    = min3(col_reg[0].hi, col_reg[1].hi, col_reg[2].hi);

endmodule

`default_nettype wire

// File: rtl/core/mf3_out_queue.sv
// Final median stage and the result sequencer that drives the output register.
`default_nettype none

module mf3_out_queue #(
    parameter int AW = 11
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    output logic                          can_load,
    input  mf3_pkg::pix_t                 in_pix,
    input  logic [mf3_pkg::PLANE_W-1:0]   in_plane,
    input  logic [AW-1:0]                 in_col,
    input  logic [mf3_pkg::COORD_W-1:0]   in_row,
    input  mf3_pkg::item_ctl_t            in_ctl,
    input  mf3_pkg::pix_t                 in_mid_prev,
    input  mf3_pkg::pix_t                 in_mid_cur,
    input  mf3_pkg::pix_t                 in_max_lo,
    input  mf3_pkg::pix_t                 in_med_md,
    input  mf3_pkg::pix_t                 in_min_hi,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [mf3_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic [mf3_pkg::PLANE_W-1:0]   m_axis_tuser,
    output logic                          m_axis_tlast
);

    import mf3_pkg::*;

    // Pending results, lowest bit first: center pixel, right edge, last row copy.
    logic [2:0]             mask_reg;
    pix_t                   pix_reg;
    logic [PLANE_W-1:0]     plane_reg;
    logic [AW-1:0]          col_reg;
    logic [COORD_W-1:0]     row_reg;
    logic                   use_med_reg;
    logic                   done_reg;
    pix_t                   mid_prev_reg;
    pix_t                   mid_cur_reg;
    pix_t                   max_lo_reg;
    pix_t                   med_md_reg;
    pix_t                   min_hi_reg;

    logic                   m_valid_reg;
    logic [OUT_DATA_W-1:0]  m_data_reg;
    logic [PLANE_W-1:0]     m_user_reg;
    logic                   m_last_reg;

    logic                   out_free;
    logic                   pick;
    logic [2:0]             pick_bit;
    logic [2:0]             mask_next;
    pix_t                   median;
    logic [31:0]            col_w;
    logic [31:0]            colm1_w;
    logic [AW-1:0]          colm1;
    logic [COORD_W-1:0]     rowm1;
    pix_t                   sel_pix;
    logic [COORD_W-1:0]     sel_col;
    logic [COORD_W-1:0]     sel_row;
    logic                   sel_last;

    always_comb
    begin
        out_free  = !m_valid_reg || m_axis_tready;
        pick      = (mask_reg != 3'b000) && out_free;
        pick_bit  = mask_reg & (~mask_reg + 3'b001);
        mask_next = mask_reg & ~pick_bit;
        can_load  = (mask_reg == 3'b000) || (out_free && (mask_next == 3'b000));

        median  = med3(max_lo_reg, med_md_reg, min_hi_reg);
        colm1   = col_reg - AW'(1);
        col_w   = 32'(col_reg);
        colm1_w = 32'(colm1);
        rowm1   = row_reg - COORD_W'(1);

        if (mask_reg[0])
        begin
            sel_pix  = use_med_reg ? median : mid_prev_reg;
            sel_col  = colm1_w[COORD_W-1:0];
            sel_row  = rowm1;
            sel_last = 1'b0;
        end
        else if (mask_reg[1])
        begin
            sel_pix  = mid_cur_reg;
            sel_col  = col_w[COORD_W-1:0];
            sel_row  = rowm1;
            sel_last = 1'b0;
        end
        else
        begin
            sel_pix  = pix_reg;
            sel_col  = col_w[COORD_W-1:0];
            sel_row  = row_reg;
            sel_last = done_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= 3'b000;
        end
        else if (load)
        begin
            mask_reg <= {in_ctl.res_self, in_ctl.res_edge, in_ctl.res_center};
        end
        else if (pick)
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pix_reg      <= in_pix;
            plane_reg    <= in_plane;
            col_reg      <= in_col;
            row_reg      <= in_row;
            use_med_reg  <= in_ctl.use_median;
            done_reg     <= in_ctl.done;
            mid_prev_reg <= in_mid_prev;
            mid_cur_reg  <= in_mid_cur;
            max_lo_reg   <= in_max_lo;
            med_md_reg   <= in_med_md;
            min_hi_reg   <= in_min_hi;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (pick)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pick)
        begin
            m_data_reg <= OUT_DATA_W'({sel_row, sel_col, sel_pix});
            m_user_reg <= plane_reg;
            m_last_reg <= sel_last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

`default_nettype wire

// File: rtl/core/median_3x3_filter.sv
// Top level of the streaming 3x3 median filter for one image plane.
`default_nettype none

// The filter takes one plane of a frame as pixels in raster order, one
// transfer per pixel, and returns every pixel of the plane once: interior
// pixels replaced by the median of their 3x3 neighborhood, border pixels
// copied unchanged. The result for pixel (c,r) leaves when input (c+1,r+1)
// has been taken; the right edge pixel of the row above follows the input
// at the last column, and on the last row every input is also sent back as
// its own copy, with tlast set on the final pixel of the plane. The plane
// index in tuser of an input transfer travels on every result it causes.
// Throughput is one pixel per clock while the output side is ready: an
// input that causes two or three results holds the input side until all
// but its last result have left, since the single output register moves
// one result per clock. The first result of an input reaches the output
// through these steps in order: the line buffer read is issued at the
// transfer edge, then come the window update with column sort, the median
// reduction and the output register. The two
// line buffers share one memory (one read and one write per cycle); its
// contents need no clearing after reset, as unwritten entries only reach
// the first two rows, which yield border copies. Frame width and height
// are written on the cfg port while the block is idle; a value below 3
// acts as 3, one above the maximum acts as the maximum, and any write
// restarts the plane at column 0, row 0.

module median_3x3_filter #(
    parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mf3_pkg::CFG_W-1:0]        cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [mf3_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // [7:0] pixel_in
    input  logic [mf3_pkg::PLANE_W-1:0]      s_axis_tuser,   // [1:0] plane_in
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [7:0] pixel_out, [18:8] out_column, [29:19] out_row, [31:30] zero
    output logic [mf3_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic [mf3_pkg::PLANE_W-1:0]      m_axis_tuser,   // [1:0] out_plane
    output logic                             m_axis_tlast    // frame_done
);

    import mf3_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WIDTH_RST = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
    localparam logic [AW-1:0]      WIDTH_RST_M1  = AW'(WIDTH_RST - 1);
    localparam logic [COORD_W-1:0] HEIGHT_RST_M1 = COORD_W'(FRAME_HEIGHT_RST - 1);

    // Clamp a written size into [3, hi] and return it minus one.
    function automatic logic [31:0] clamp_m1(input logic [CFG_W-1:0] v,
                                             input logic [31:0] hi);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v32 < 32'd3)
        begin
            v32 = 32'd3;
        end
        else if (v32 > hi)
        begin
            v32 = hi;
        end
        return v32 - 32'd1;
    endfunction

    // Size registers hold the effective size minus one.
    logic [AW-1:0]          width_m1_reg;
    logic [COORD_W-1:0]     height_m1_reg;
    logic [31:0]            cfg_w_m1;
    logic [31:0]            cfg_h_m1;

    // Raster position of the next input transfer.
    logic [AW-1:0]          col_reg;
    logic [COORD_W-1:0]     row_reg;
    logic [AW-1:0]          col_next;
    logic [COORD_W-1:0]     row_next;

    // Stage 1: the accepted pixel waits for its line buffer read.
    logic                   s1_valid_reg;
    pix_t                   s1_pix_reg;
    logic [PLANE_W-1:0]     s1_plane_reg;
    logic [AW-1:0]          s1_col_reg;
    logic [COORD_W-1:0]     s1_row_reg;
    item_ctl_t              s1_ctl_reg;

    // Stage 2: the window holds the item.
    logic                   s2_valid_reg;

    logic                   last_col;
    logic                   last_row;
    item_ctl_t              ctl_in;
    logic                   s_accept;
    logic                   s1_advance;
    logic                   s2_advance;
    logic                   s1_free;
    logic                   s2_free;
    logic                   s3_free;

    logic [2*PIXEL_BITS-1:0] lb_rd_data;
    pix_t                   lb_two_above;
    pix_t                   lb_above;

    pix_t                   win_pix;
    logic [PLANE_W-1:0]     win_plane;
    logic [AW-1:0]          win_col;
    logic [COORD_W-1:0]     win_row;
    item_ctl_t              win_ctl;
    pix_t                   mid_prev;
    pix_t                   mid_cur;
    pix_t                   max_lo;
    pix_t                   med_md;
    pix_t                   min_hi;

    always_comb
    begin
        cfg_w_m1 = clamp_m1(cfg_data, 32'(MAX_WIDTH));
        cfg_h_m1 = clamp_m1(cfg_data, 32'(MAX_HEIGHT));
    end

    // Results each input causes follow from its position alone.
    always_comb
    begin
        last_col = (col_reg == width_m1_reg);
        last_row = (row_reg == height_m1_reg);

        ctl_in.res_center = (row_reg != '0) && (col_reg != '0);
        ctl_in.use_median = (row_reg > COORD_W'(1)) && (col_reg > AW'(1));
        ctl_in.res_edge   = (row_reg != '0) && last_col;
        ctl_in.res_self   = last_row;
        ctl_in.done       = last_row && last_col;

        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + COORD_W'(1);
        end
        else
        begin
            col_next = col_reg + AW'(1);
            row_next = row_reg;
        end
    end

    // Pipeline flow: each stage moves on when the one after it can take the item.
    always_comb
    begin
        s2_free       = !s2_valid_reg || s3_free;
        s2_advance    = s2_valid_reg && s3_free;
        s1_free       = !s1_valid_reg || s2_free;
        s1_advance    = s1_valid_reg && s2_free;
        s_axis_tready = s1_free;
        s_accept      = s_axis_tvalid && s1_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_m1_reg  <= WIDTH_RST_M1;
            height_m1_reg <= HEIGHT_RST_M1;
            col_reg       <= '0;
            row_reg       <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_m1_reg  <= cfg_w_m1[AW-1:0];
                REG_FRAME_HEIGHT: height_m1_reg <= cfg_h_m1[COORD_W-1:0];
            endcase
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (s_accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_advance)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_advance)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_pix_reg   <= s_axis_tdata[PIXEL_BITS-1:0];
            s1_plane_reg <= s_axis_tuser;
            s1_col_reg   <= col_reg;
            s1_row_reg   <= row_reg;
            s1_ctl_reg   <= ctl_in;
        end
    end

    // The read is issued with the transfer; the write back happens when the
    // item enters the window. Consecutive items always sit in different columns.
    assign lb_two_above = lb_rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
    assign lb_above     = lb_rd_data[PIXEL_BITS-1:0];

    mf3_line_buf #(
        .DEPTH (MAX_WIDTH),
        .DW    (2 * PIXEL_BITS)
    ) u_line_buf (
        .clk     (clk),
        .rd_en   (s_accept),
        .rd_addr (col_reg),
        .rd_data (lb_rd_data),
        .wr_en   (s1_advance),
        .wr_addr (s1_col_reg),
        .wr_data ({lb_above, s1_pix_reg})
    );

    mf3_window #(
        .AW (AW)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s1_advance),
        .new_top   (lb_two_above),
        .new_mid   (lb_above),
        .new_bot   (s1_pix_reg),
        .in_plane  (s1_plane_reg),
        .in_col    (s1_col_reg),
        .in_row    (s1_row_reg),
        .in_ctl    (s1_ctl_reg),
        .win_pix   (win_pix),
        .win_plane (win_plane),
        .win_col   (win_col),
        .win_row   (win_row),
        .win_ctl   (win_ctl),
        .mid_prev  (mid_prev),
        .mid_cur   (mid_cur),
        .max_lo    (max_lo),
        .med_md    (med_md),
        .min_hi    (min_hi)
    );

    mf3_out_queue #(
        .AW (AW)
    ) u_out_queue (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (s2_advance),
        .can_load      (s3_free),
        .in_pix        (win_pix),
        .in_plane      (win_plane),
        .in_col        (win_col),
        .in_row        (win_row),
        .in_ctl        (win_ctl),
        .in_mid_prev   (mid_prev),
        .in_mid_cur    (mid_cur),
        .in_max_lo     (max_lo),
        .in_med_md     (med_md),
        .in_min_hi     (min_hi),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef SYNTH
    // The raster position never leaves the configured frame.
    a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= width_m1_reg)
        else $error("column counter beyond frame width");

    a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= height_m1_reg)
        else $error("row counter beyond frame height");

    // A line buffer read never targets the entry being written back.
    a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s1_advance) |-> (col_reg != s1_col_reg))
        else $error("line buffer read and write hit the same column");

    // An item in stage 1 that cannot move on keeps stage 1 occupied.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_free) |=> s1_valid_reg)
        else $error("stage 1 item lost under back pressure");
`endif

endmodule

`default_nettype wire

// File: tb/median_plane_checker.sv
// Watches the ports of the 3x3 median filter, predicts every filtered pixel and checks it.
`timescale 1ns / 1ps

module median_plane_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mf3_pkg::CFG_W-1:0]        cfg_data,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [mf3_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  logic [mf3_pkg::PLANE_W-1:0]      s_axis_tuser,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [mf3_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic [mf3_pkg::PLANE_W-1:0]      m_axis_tuser,
    input  logic                             m_axis_tlast,
    output int                               error_count,
    output int                               pending_count
);
    import mf3_pkg::*;

    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel;
        logic [COORD_W-1:0]    column;
        logic [COORD_W-1:0]    row;
        logic [PLANE_W-1:0]    plane;
        logic                  last;
    } filtered_pixel_t;

    bit [PIXEL_BITS-1:0] prev_row  [MAX_WIDTH_DEF];
    bit [PIXEL_BITS-1:0] prev_row2 [MAX_WIDTH_DEF];
    bit [PIXEL_BITS-1:0] win [9];
    int unsigned         col_pos;
    int unsigned         row_pos;
    int unsigned         width_reg;
    int unsigned         height_reg;
    filtered_pixel_t     pending_pixels [$];

    initial error_count = 0;

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    // The median is the value with at most four smaller and at least five not larger.
    function automatic bit [PIXEL_BITS-1:0] median_of_nine(input bit [PIXEL_BITS-1:0] w [9]);
        int below;
        int not_above;
        for (int i = 0; i < 9; i++) begin
            below     = 0;
            not_above = 0;
            for (int j = 0; j < 9; j++) begin
                if (w[j] < w[i])
                    below++;
                if (w[j] <= w[i])
                    not_above++;
            end
            if (below <= 4 && not_above >= 5)
                return w[i];
        end
        return w[4];
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want, input filtered_pixel_t at);
        if (error_count < PRINT_LIMIT)
            $display("%0t: %s at column %0d row %0d: got %0d, expected %0d",
                     $time, what, at.column, at.row, got, want);
        error_count++;
    endtask

    task automatic expect_pixel(input int unsigned pix, input int unsigned col,
                                input int unsigned row, input logic [PLANE_W-1:0] plane,
                                input logic last);
        filtered_pixel_t item;
        item.pixel  = PIXEL_BITS'(pix);
        item.column = COORD_W'(col);
        item.row    = COORD_W'(row);
        item.plane  = plane;
        item.last   = last;
        pending_pixels.push_back(item);
    endtask

    task automatic filter_pixel(input bit [PIXEL_BITS-1:0] pix, input logic [PLANE_W-1:0] plane);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        w = clamp_dim(width_reg, MAX_WIDTH_DEF);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        c = (col_pos >= w) ? w - 1 : col_pos;
        r = (row_pos >= h) ? h - 1 : row_pos;

        // Window moves one column left; the new right column is rows r-2, r-1, r at column c.
        win[0] = win[1];
        win[1] = win[2];
        win[3] = win[4];
        win[4] = win[5];
        win[6] = win[7];
        win[7] = win[8];
        win[2] = prev_row2[c];
        win[5] = prev_row[c];
        win[8] = pix;
        prev_row2[c] = prev_row[c];
        prev_row[c]  = pix;

        if (r >= 1) begin
            if (c >= 1)
                expect_pixel((c >= 2 && r >= 2) ? median_of_nine(win) : win[4],
                             c - 1, r - 1, plane, 1'b0);
            if (c == w - 1)
                expect_pixel(win[5], c, r - 1, plane, 1'b0);
        end
        if (r == h - 1)
            expect_pixel(pix, c, r, plane, c == w - 1);

        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    task automatic check_result();
        filtered_pixel_t got;
        filtered_pixel_t want;
        got.pixel  = m_axis_tdata[PIXEL_BITS-1:0];
        got.column = m_axis_tdata[PIXEL_BITS +: COORD_W];
        got.row    = m_axis_tdata[PIXEL_BITS + COORD_W +: COORD_W];
        got.plane  = m_axis_tuser;
        got.last   = m_axis_tlast;
        if (pending_pixels.size() == 0) begin
            report_mismatch("result with none expected", got.pixel, 0, got);
            return;
        end
        want = pending_pixels.pop_front();
        if (got.pixel != want.pixel)
            report_mismatch("pixel", got.pixel, want.pixel, want);
        if (got.column != want.column)
            report_mismatch("column", got.column, want.column, want);
        if (got.row != want.row)
            report_mismatch("row", got.row, want.row, want);
        if (got.plane != want.plane)
            report_mismatch("plane", got.plane, want.plane, want);
        if (got.last != want.last)
            report_mismatch("frame done", got.last, want.last, want);
        if (m_axis_tdata[OUT_DATA_W-1:PIXEL_BITS + 2 * COORD_W] != '0)
            report_mismatch("tdata padding", m_axis_tdata[OUT_DATA_W-1:PIXEL_BITS + 2 * COORD_W],
                            0, want);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            foreach (win[i])
                win[i] = '0;
            col_pos    = 0;
            row_pos    = 0;
            width_reg  = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            pending_pixels.delete();
        end
        else begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (cfg_we) begin
                if (cfg_index == REG_FRAME_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
                col_pos = 0;
                row_pos = 0;
            end
            if (s_axis_tvalid && s_axis_tready)
                filter_pixel(s_axis_tdata[PIXEL_BITS-1:0], s_axis_tuser);
        end
        pending_count = pending_pixels.size();
    end

endmodule

// File: tb/tb_median_3x3_filter.sv
// Stimulus and verdict for the 3x3 median filter, checked by median_plane_checker.
`timescale 1ns / 1ps

module tb_median_3x3_filter;
    import mf3_pkg::*;

    // No transfer of any kind for this many cycles means the block has hung.
    // The quietest correct stretch is the settle pause before a register write,
    // so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles allowed after the last expected result before the block counts as
    // idle: the pipeline latency plus margin for pixels in flight that produce
    // no result (first row of a plane).
    localparam int SETTLE_CYCLES  = 12;
    localparam int RANDOM_ITEMS   = 250;
    localparam int GAP_PERCENT    = 26;
    // Pixels sent into each of the large planes, which are never finished.
    localparam int PROBE_ITEMS    = 20;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;    // [7:0] pixel_in
    logic [PLANE_W-1:0]    s_axis_tuser;    // [1:0] plane_in
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [7:0] pixel_out, [18:8] out_column, [29:19] out_row, [31:30] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [PLANE_W-1:0]    m_axis_tuser;    // [1:0] out_plane
    logic                  m_axis_tlast;    // frame_done

    int error_count;
    int pending_count;
    int stall_cycles;
    // While set, neither side inserts gaps: one long back-to-back stretch.
    bit steady;

    // A 3x3 plane has a single interior pixel; the values cover both extremes
    // and alternating bit patterns.
    pix_t corner_plane [9] = '{8'd0, 8'd255, 8'd170, 8'd85, 8'd1, 8'd128, 8'd254,
                               8'd127, 8'd255};
    // A 5x3 plane with many equal values, so medians are decided by ties.
    pix_t strip_plane [15] = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255,
                               8'd0, 8'd255, 8'd0, 8'd255, 8'd0,
                               8'd255, 8'd255, 8'd0, 8'd0, 8'd128};

    median_3x3_filter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    median_plane_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // The receiver stalls at random, changing its ready at the falling edge.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge clk);
            m_axis_tready <= steady || ($urandom_range(99) >= GAP_PERCENT);
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            stall_cycles <= 0;
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("tb_median_3x3_filter: errors");
        $finish;
    end

    // Pixel content styles: full range, four levels, the two extremes, and a
    // narrow band that makes near-ties in the median network.
    function automatic pix_t pick_pixel(input int unsigned style);
        case (style)
            0:       return pix_t'($urandom_range(255));
            1:       return pix_t'($urandom_range(3) * 85);
            2:       return $urandom_range(1) ? 8'd255 : 8'd0;
            default: return pix_t'($urandom_range(103, 100));
        endcase
    endfunction

    // One pixel transfer. The sender may idle first; tvalid is left high on
    // return so that a following pixel goes out back to back.
    task automatic send_pixel(input pix_t pix, input logic [PLANE_W-1:0] plane);
        while (!steady && $urandom_range(99) < GAP_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'(pix);
        s_axis_tuser  <= plane;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Hold the input side until every predicted pixel has come out.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    task automatic send_random_pixels(input int unsigned count, input int unsigned style);
        for (int unsigned i = 0; i < count; i++) begin
            send_pixel(pick_pixel(style), PLANE_W'($urandom_range(3)));
            // Now and then the sender stops until the output side has caught up.
            if ($urandom_range(199) == 0)
                wait_drained();
        end
    endtask

    // Both size registers are written with the block idle; a write also
    // restarts the plane at column 0, row 0.
    task automatic set_frame(input logic [CFG_W-1:0] width_val, input logic [CFG_W-1:0] height_val);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= width_val;
        @(negedge clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= height_val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        int unsigned sent;
        int unsigned plane_no;
        int unsigned width_val;
        int unsigned height_val;
        int unsigned count;

        rst_n         = 1'b0;
        steady        = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_FRAME_WIDTH;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset sizes: a short stretch of the first row of a 640 wide plane,
        // which must yield no result at all.
        send_random_pixels(PROBE_ITEMS, 0);

        // Sizes below 3 act as 3: the smallest plane, one interior pixel.
        set_frame(CFG_W'(0), CFG_W'(2));
        foreach (corner_plane[i])
            send_pixel(corner_plane[i], PLANE_W'(i));

        // A 5x3 plane: three medians in a row, edge copies and the last row.
        set_frame(CFG_W'(5), CFG_W'(3));
        foreach (strip_plane[i])
            send_pixel(strip_plane[i], PLANE_W'(3 - i % 4));

        // Random planes, mostly small. Some stop part way, so the next size
        // write restarts a plane in the middle. Three planes run with no gaps.
        sent     = 0;
        plane_no = 0;
        while (sent < RANDOM_ITEMS) begin
            width_val  = ($urandom_range(9) == 0) ? $urandom_range(2, 0) : $urandom_range(10, 3);
            height_val = ($urandom_range(9) == 0) ? $urandom_range(2, 0) : $urandom_range(6, 3);
            set_frame(CFG_W'(width_val), CFG_W'(height_val));
            steady <= (plane_no >= 3) && (plane_no <= 5);
            count = (width_val < 3 ? 3 : width_val) * (height_val < 3 ? 3 : height_val);
            if ($urandom_range(4) == 0)
                count = $urandom_range(count - 1, 1);
            send_random_pixels(count, $urandom_range(3));
            sent += count;
            plane_no++;
        end
        steady <= 1'b0;

        // All ones in both registers acts as the maximum: the start of the
        // first row of the largest plane, then the plane is cut short.
        set_frame(CFG_W'(12'hFFF), CFG_W'(12'hFFF));
        send_random_pixels(PROBE_ITEMS, 0);

        // The narrowest plane at the greatest height: its first rows.
        set_frame(CFG_W'(1), CFG_W'(12'hFFF));
        send_random_pixels(PROBE_ITEMS + 4, $urandom_range(3));

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("tb_median_3x3_filter: clean");
        else
            $display("tb_median_3x3_filter: errors");
        $finish;
    end

endmodule
